>>> design/tma_pkg.sv
package tma_pkg;

	localparam int WINDOW_MAX_DEF  = 64;
	localparam int SAMPLE_BITS_DEF = 32;

	// window_length register
	localparam int CFG_BITS     = 7;
	localparam int WINDOW_RESET = 5;

endpackage

>>> design/tma_stream_if.sv
interface tma_in_if #(
	parameter int SAMPLE_BITS = tma_pkg::SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                          start_of_track;

	modport source (output valid, output sample, output start_of_track, input ready);
	modport sink   (input valid, input sample, input start_of_track, output ready);
endinterface

interface tma_out_if #(
	parameter int SAMPLE_BITS = tma_pkg::SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] value;
	logic                          smoothed;

	modport source (output valid, output value, output smoothed, input ready);
	modport sink   (input valid, input value, input smoothed, output ready);
endinterface

>>> design/trailing_moving_average.sv
// channel    | dir | handshake   | word
// sample_ch  | in  | valid/ready | sample, start_of_track
// result_ch  | out | valid/ready | value, smoothed
// cfg        | in  | cfg_we      | cfg_wdata = window_length
//
// One word at a time. A smoothed result passes through these steps in order: the accepting
// edge reads the delay line, ST_READ updates the sum, ST_DIV runs the one-bit-a-cycle
// restoring divider over the SUM_BITS-bit dividend, and ST_DONE loads the output register.
// A passed-through sample skips ST_DIV. The next word is accepted once the result loads.
// The next word is taken while the result register still waits on result_ch.ready;
// a stalled result holds the sequencer in its last state. arst_n clears control
// state and sets window_length to 5; the delay line is not cleared.
module trailing_moving_average #(
	parameter int WINDOW_MAX  = tma_pkg::WINDOW_MAX_DEF,
	parameter int SAMPLE_BITS = tma_pkg::SAMPLE_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	tma_in_if.sink                      sample_ch,
	tma_out_if.source                   result_ch,
	input  logic                        cfg_we,
	input  logic [tma_pkg::CFG_BITS-1:0] cfg_wdata
);

	localparam int AW       = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int WIN_BITS = $clog2(WINDOW_MAX + 1);
	localparam int SUM_BITS = SAMPLE_BITS + AW;
	localparam int CNT_BITS = $clog2(SUM_BITS);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t                        state_q;
	logic [tma_pkg::CFG_BITS-1:0]  window_length_q;
	logic signed [SUM_BITS-1:0]    sum_q;
	logic [AW-1:0]                 wp_q;
	logic [WIN_BITS-1:0]           seen_q;
	logic [WIN_BITS-1:0]           win_q;
	logic signed [SAMPLE_BITS-1:0] x_q;
	logic [SUM_BITS-1:0]           dvd_q;
	logic [WIN_BITS-1:0]           rem_q;
	logic [CNT_BITS-1:0]           cnt_q;
	logic                          neg_q;
	logic                          full_q;
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] value_q;
	logic                          smoothed_q;

	logic signed [SAMPLE_BITS-1:0] mem [WINDOW_MAX];
	logic signed [SAMPLE_BITS-1:0] rd_q;

	logic                          accept;
	logic [WIN_BITS-1:0]           win_eff;
	logic [AW-1:0]                 wp_cur;
	logic [AW:0]                   old_sum;
	logic [AW-1:0]                 old_idx;
	logic signed [SUM_BITS-1:0]    sum_next;
	logic [WIN_BITS-1:0]           seen_next;
	logic                          full_next;
	logic [WIN_BITS:0]             rem_sh;
	logic                          q_bit;
	logic [SUM_BITS-1:0]           quot;
	logic                          out_free;

	assign accept          = sample_ch.valid && sample_ch.ready;
	assign sample_ch.ready = (state_q == ST_IDLE);
	assign result_ch.valid = out_valid_q;
	assign result_ch.value = value_q;
	assign result_ch.smoothed = smoothed_q;
	assign out_free        = !out_valid_q || result_ch.ready;

	always_comb begin
		if (window_length_q == '0) begin
			win_eff = WIN_BITS'(1);
		end else if (int'(window_length_q) > WINDOW_MAX) begin
			win_eff = WIN_BITS'(WINDOW_MAX);
		end else begin
			win_eff = WIN_BITS'(window_length_q);
		end
	end

	// slot of the sample leaving the window, modulo WINDOW_MAX
	always_comb begin
		wp_cur  = sample_ch.start_of_track ? '0 : wp_q;
		old_sum = {1'b0, wp_cur} + (AW+1)'(WINDOW_MAX) - (AW+1)'(win_eff);
		if (old_sum >= (AW+1)'(WINDOW_MAX)) begin
			old_idx = AW'(old_sum - (AW+1)'(WINDOW_MAX));
		end else begin
			old_idx = AW'(old_sum);
		end
	end

	always_comb begin
		sum_next = sum_q + SUM_BITS'(x_q);
		if (seen_q >= win_q) begin
			sum_next = sum_next - SUM_BITS'(rd_q);
		end
		seen_next = (seen_q < win_q) ? seen_q + 1'b1 : seen_q;
		full_next = (seen_next >= win_q);
	end

	always_comb begin
		rem_sh = {rem_q, dvd_q[SUM_BITS-1]};
		q_bit  = (rem_sh >= {1'b0, win_q});
		quot   = neg_q ? (~dvd_q + 1'b1) : dvd_q;
	end

	// delay line: read the leaving slot at accept, write the new sample in ST_READ
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_q <= mem[old_idx];
		end
		if (state_q == ST_READ) begin
			mem[wp_q] <= x_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			window_length_q <= tma_pkg::CFG_BITS'(tma_pkg::WINDOW_RESET);
			sum_q           <= '0;
			wp_q            <= '0;
			seen_q          <= '0;
			out_valid_q     <= 1'b0;
			win_q           <= '0;
			x_q             <= '0;
			dvd_q           <= '0;
			rem_q           <= '0;
			cnt_q           <= '0;
			neg_q           <= 1'b0;
			full_q          <= 1'b0;
			value_q         <= '0;
			smoothed_q      <= 1'b0;
		end else begin
			if (out_valid_q && result_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				window_length_q <= cfg_wdata;
				sum_q           <= '0;
				wp_q            <= '0;
				seen_q          <= '0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						x_q   <= sample_ch.sample;
						win_q <= win_eff;
						wp_q  <= wp_cur;
						if (sample_ch.start_of_track) begin
							sum_q  <= '0;
							seen_q <= '0;
						end
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					sum_q  <= sum_next;
					seen_q <= seen_next;
					wp_q   <= (int'(wp_q) == WINDOW_MAX - 1) ? '0 : wp_q + 1'b1;
					full_q <= full_next;
					rem_q  <= '0;
					cnt_q  <= '0;
					if (full_next) begin
						neg_q   <= sum_next[SUM_BITS-1];
						dvd_q   <= sum_next[SUM_BITS-1] ? SUM_BITS'(-sum_next)
							: SUM_BITS'(sum_next);
						state_q <= ST_DIV;
					end else begin
						// pass through: quotient register carries the raw sample
						neg_q   <= 1'b0;
						dvd_q   <= SUM_BITS'(x_q);
						state_q <= ST_DONE;
					end
				end
				ST_DIV: begin
					rem_q <= q_bit ? WIN_BITS'(rem_sh - {1'b0, win_q}) : WIN_BITS'(rem_sh);
					dvd_q <= {dvd_q[SUM_BITS-2:0], q_bit};
					cnt_q <= cnt_q + 1'b1;
					if (int'(cnt_q) == SUM_BITS - 1) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						value_q     <= quot[SAMPLE_BITS-1:0];
						smoothed_q  <= full_q;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> design/tma_checker.sv
module tma_checker #(
	parameter int SAMPLE_BITS = tma_pkg::SAMPLE_BITS_DEF
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [SAMPLE_BITS-1:0] value,
	input logic                   smoothed
);

	// hold a stalled result word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(value) && $stable(smoothed))
		else $error("result word changed or dropped while stalled");

	// an accepted word keeps the input closed through its read and sum update
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready ##1 !in_ready)
		else $error("input reopened before the word was processed");

	// a new result is loaded only from a busy cycle
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared without a word in flight");

endmodule

bind trailing_moving_average tma_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_tma_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (sample_ch.valid),
	.in_ready  (sample_ch.ready),
	.out_valid (result_ch.valid),
	.out_ready (result_ch.ready),
	.value     (result_ch.value),
	.smoothed  (result_ch.smoothed)
);
